// ===== hw/rtl/rbcb_pkg.sv =====
// Shared types, field widths, codes and reset values for the retry/breaker core.
// Used by the channel interfaces, the top level and the testbench.
package rbcb_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned MODE_W     = 1;
  localparam int unsigned ENDPOINT_W = 4;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned DRAW_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DELAY_W    = 25;

  // Configuration register widths.
  localparam int unsigned RETRIES_W   = 4;
  localparam int unsigned BASE_W      = 16;
  localparam int unsigned BACKOFF_W   = 24;
  localparam int unsigned JITTER_W    = 8;
  localparam int unsigned THRESHOLD_W = 8;
  localparam int unsigned FAILCNT_W   = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOFF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_FRAC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BREAKER_RESET  = 3'd5;

  // Register reset values.
  localparam logic [RETRIES_W-1:0]   RETRY_LIMIT_RST    = 4'd3;
  localparam logic [BASE_W-1:0]      BASE_DELAY_RST     = 16'd100;
  localparam logic [BACKOFF_W-1:0]   MAX_BACKOFF_RST    = 24'd5000;
  localparam logic [JITTER_W-1:0]    JITTER_FRAC_RST    = 8'd64;
  localparam logic [THRESHOLD_W-1:0] FAIL_THRESHOLD_RST = 8'd5;
  localparam logic [TIME_W-1:0]      BREAKER_RESET_RST  = 32'd30000;

  // Default number of breaker entries.
  localparam int unsigned ENDPOINT_COUNT_DEF = 16;

  // Number of distinct endpoint codes on the request channel.
  localparam int unsigned EP_CODES = 2 ** ENDPOINT_W;

  // Serial multiplier sizing: the accumulator holds draw times (2j + 1).
  localparam int unsigned ACC_W   = DELAY_W + DRAW_W;
  localparam int unsigned SHIFT_W = BASE_W + 2 ** RETRIES_W - 1;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_START   = 1'b0;
  localparam logic [MODE_W-1:0] MODE_OUTCOME = 1'b1;

  // Attempt outcomes.
  localparam logic [OUTCOME_W-1:0] OUT_OK        = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_RETRYABLE = 2'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_WAIT   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_ERROR  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK           = 2'd0,
    STS_RETRYABLE    = 2'd1,
    STS_NONRETRYABLE = 2'd2,
    STS_BREAKER_OPEN = 2'd3
  } status_e;

  // One breaker entry as kept in the endpoint RAM.
  typedef struct packed {
    logic [FAILCNT_W-1:0] fail_cnt;
    logic [TIME_W-1:0]    fail_time;
  } ep_entry_t;

endpackage

// ===== hw/rtl/rbcb_in_if.sv =====
// Request channel: valid/ready handshake carrying one start or outcome item.
// Depends on rbcb_pkg for the field widths.
interface rbcb_in_if;
  logic                                valid;
  logic                                ready;
  logic [rbcb_pkg::MODE_W-1:0]         mode;
  logic [rbcb_pkg::ENDPOINT_W-1:0]     endpoint;
  logic [rbcb_pkg::OUTCOME_W-1:0]      outcome;
  logic [rbcb_pkg::DRAW_W-1:0]         random_draw;
  logic [rbcb_pkg::TIME_W-1:0]         now_ms;

  modport source (output valid, mode, endpoint, outcome, random_draw, now_ms,
                  input ready);
  modport sink (input valid, mode, endpoint, outcome, random_draw, now_ms,
                output ready);
endinterface

// ===== hw/rtl/rbcb_out_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
// Depends on rbcb_pkg for the field widths.
interface rbcb_out_if;
  logic                              valid;
  logic                              ready;
  logic [rbcb_pkg::ACTION_W-1:0]     action;
  logic [rbcb_pkg::STATUS_W-1:0]     final_status;
  logic [rbcb_pkg::DELAY_W-1:0]      delay_ms;
  logic                              breaker_opened;

  modport source (output valid, action, final_status, delay_ms, breaker_opened,
                  input ready);
  modport sink (input valid, action, final_status, delay_ms, breaker_opened,
                output ready);
endinterface

// ===== hw/rtl/retry_backoff_circuit_breaker_core.sv =====
// Retry controller with per-endpoint circuit breakers and jittered backoff.
// Depends on rbcb_pkg, rbcb_in_if, rbcb_out_if and rbcb_ram.
//
// Usage: a request on in_i is either a start (mode 0, checks the breaker of
// the chosen endpoint) or an outcome report for the current attempt (mode 1).
// Every request produces exactly one result on out_o: submit, wait with a
// delay, finished with a status, or protocol error. Registers are to be written
// on the cfg_* port only while the block is idle; the block does not enforce it.
//
// Timing: a request is taken only while the controller is idle. A request
// that needs no backoff passes through the decide and done states before its
// result is registered. A retryable outcome that computes a delay runs a
// bit-serial shift-add multiplier: 8 steps for the jitter width, then 16 steps
// over the random draw, with a middle step between and a sum step after (the
// second pass is skipped if the jitter amount is zero).
//
// Reset clears all breakers, failure counts and times (per-entry valid bits
// make unwritten RAM entries read as zero), and loads the register defaults.
// The result register decouples the sides: a new request is taken while a
// result waits; a stalled receiver holds the result and the next one waits.
module retry_backoff_circuit_breaker_core #(
  parameter int unsigned ENDPOINT_COUNT = rbcb_pkg::ENDPOINT_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbcb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rbcb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  rbcb_in_if.sink                            in_i,
  rbcb_out_if.source                         out_o
);

  localparam int unsigned EP_W   = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
  localparam int unsigned STEP_W = $clog2(rbcb_pkg::DRAW_W);
  localparam logic [STEP_W-1:0] MUL1_LAST = STEP_W'(rbcb_pkg::JITTER_W - 1);
  localparam logic [STEP_W-1:0] MUL2_LAST = STEP_W'(rbcb_pkg::DRAW_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_MUL1   = 7'b0000100,
    ST_MID    = 7'b0001000,
    ST_MUL2   = 7'b0010000,
    ST_SUM    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  // Configuration registers.
  logic [rbcb_pkg::RETRIES_W-1:0]   retry_limit_q;
  logic [rbcb_pkg::BASE_W-1:0]      base_delay_q;
  logic [rbcb_pkg::BACKOFF_W-1:0]   max_backoff_q;
  logic [rbcb_pkg::JITTER_W-1:0]    jitter_frac_q;
  logic [rbcb_pkg::THRESHOLD_W-1:0] fail_thresh_q;
  logic [rbcb_pkg::TIME_W-1:0]      brk_reset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= rbcb_pkg::RETRY_LIMIT_RST;
      base_delay_q  <= rbcb_pkg::BASE_DELAY_RST;
      max_backoff_q <= rbcb_pkg::MAX_BACKOFF_RST;
      jitter_frac_q <= rbcb_pkg::JITTER_FRAC_RST;
      fail_thresh_q <= rbcb_pkg::FAIL_THRESHOLD_RST;
      brk_reset_q   <= rbcb_pkg::BREAKER_RESET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbcb_pkg::REG_RETRY_LIMIT:    retry_limit_q <= cfg_wdata_i[rbcb_pkg::RETRIES_W-1:0];
        rbcb_pkg::REG_BASE_DELAY:     base_delay_q  <= cfg_wdata_i[rbcb_pkg::BASE_W-1:0];
        rbcb_pkg::REG_MAX_BACKOFF:    max_backoff_q <= cfg_wdata_i[rbcb_pkg::BACKOFF_W-1:0];
        rbcb_pkg::REG_JITTER_FRAC:    jitter_frac_q <= cfg_wdata_i[rbcb_pkg::JITTER_W-1:0];
        rbcb_pkg::REG_FAIL_THRESHOLD: fail_thresh_q <= cfg_wdata_i[rbcb_pkg::THRESHOLD_W-1:0];
        rbcb_pkg::REG_BREAKER_RESET:  brk_reset_q   <= cfg_wdata_i[rbcb_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Endpoint code to breaker entry, folded at elaboration.
  logic [EP_W-1:0] ep_map [rbcb_pkg::EP_CODES];
  for (genvar g = 0; g < rbcb_pkg::EP_CODES; g++) begin : g_ep_map
    assign ep_map[g] = EP_W'(g % ENDPOINT_COUNT);
  end

  // Control and datapath registers.
  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic [EP_W-1:0] cur_ep_q, cur_ep_d;
  logic [rbcb_pkg::RETRIES_W-1:0] attempt_q, attempt_d;
  logic [ENDPOINT_COUNT-1:0] bo_q, bo_d;
  logic [ENDPOINT_COUNT-1:0] ent_vld_q, ent_vld_d;

  logic [rbcb_pkg::MODE_W-1:0]    mode_q;
  logic [rbcb_pkg::OUTCOME_W-1:0] outcome_q;
  logic [rbcb_pkg::DRAW_W-1:0]    draw_q;
  logic [rbcb_pkg::TIME_W-1:0]    now_q;
  logic [EP_W-1:0]                ep_q;

  logic [rbcb_pkg::BACKOFF_W-1:0] b_q, b_d;
  logic [rbcb_pkg::BACKOFF_W-1:0] j_q, j_d;
  logic [rbcb_pkg::ACC_W-1:0]     acc_q, acc_d;
  logic [rbcb_pkg::DELAY_W-1:0]   mcand_q, mcand_d;
  logic [rbcb_pkg::DRAW_W-1:0]    mplier_q, mplier_d;
  logic [STEP_W-1:0]              step_q, step_d;

  rbcb_pkg::action_e            res_act_q, res_act_d;
  rbcb_pkg::status_e            res_sts_q, res_sts_d;
  logic [rbcb_pkg::DELAY_W-1:0] res_delay_q, res_delay_d;
  logic                         res_open_q, res_open_d;

  logic                         out_vld_q;
  rbcb_pkg::action_e            out_act_q;
  rbcb_pkg::status_e            out_sts_q;
  logic [rbcb_pkg::DELAY_W-1:0] out_delay_q;
  logic                         out_open_q;

  logic in_fire;
  logic out_load;

  // Endpoint RAM signals.
  logic                  ram_we;
  logic [EP_W-1:0]       rd_addr;
  rbcb_pkg::ep_entry_t   ram_wdata;
  rbcb_pkg::ep_entry_t   ram_rdata;
  rbcb_pkg::ep_entry_t   ent;

  // Decision helpers.
  logic [rbcb_pkg::TIME_W-1:0]    age;
  logic                           expired;
  logic [rbcb_pkg::SHIFT_W-1:0]   shifted;
  logic [rbcb_pkg::BACKOFF_W-1:0] b_cap;
  logic [rbcb_pkg::FAILCNT_W-1:0] cnt_inc;
  logic [rbcb_pkg::BACKOFF_W-1:0] j_new;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  // The entry is read at acceptance; its data is ready in the decide cycle.
  assign rd_addr = (in_i.mode == rbcb_pkg::MODE_OUTCOME) ? cur_ep_q : ep_map[in_i.endpoint];

  rbcb_ram #(
    .WIDTH ($bits(rbcb_pkg::ep_entry_t)),
    .DEPTH (ENDPOINT_COUNT)
  ) u_ep_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ep_q),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Entries never written read as zero.
  assign ent = ent_vld_q[ep_q] ? ram_rdata : '0;

  assign age     = now_q - ent.fail_time;
  assign expired = age > brk_reset_q;
  assign shifted = {{(rbcb_pkg::SHIFT_W - rbcb_pkg::BASE_W){1'b0}}, base_delay_q} << attempt_q;
  assign b_cap   = (shifted > {{(rbcb_pkg::SHIFT_W - rbcb_pkg::BACKOFF_W){1'b0}}, max_backoff_q})
                   ? max_backoff_q : shifted[rbcb_pkg::BACKOFF_W-1:0];
  assign cnt_inc = (ent.fail_cnt == '1) ? ent.fail_cnt : ent.fail_cnt + 1'b1;
  assign j_new   = acc_q[rbcb_pkg::JITTER_W +: rbcb_pkg::BACKOFF_W];

  // Request decision and backoff sequencing.
  always_comb begin
    state_d     = state_q;
    busy_d      = busy_q;
    cur_ep_d    = cur_ep_q;
    attempt_d   = attempt_q;
    bo_d        = bo_q;
    ent_vld_d   = ent_vld_q;
    b_d         = b_q;
    j_d         = j_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    step_d      = step_q;
    res_act_d   = res_act_q;
    res_sts_d   = res_sts_q;
    res_delay_d = res_delay_q;
    res_open_d  = res_open_q;
    ram_we      = 1'b0;
    ram_wdata   = ent;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d     = ST_DONE;
        res_act_d   = rbcb_pkg::ACT_SUBMIT;
        res_sts_d   = rbcb_pkg::STS_OK;
        res_delay_d = '0;
        res_open_d  = 1'b0;
        if (mode_q == rbcb_pkg::MODE_START) begin
          if (busy_q) begin
            res_act_d = rbcb_pkg::ACT_ERROR;
          end else if (bo_q[ep_q] && !expired) begin
            res_act_d = rbcb_pkg::ACT_FINISH;
            res_sts_d = rbcb_pkg::STS_BREAKER_OPEN;
          end else begin
            // An open breaker whose hold time has passed closes here.
            if (bo_q[ep_q]) begin
              bo_d[ep_q]         = 1'b0;
              ram_we             = 1'b1;
              ram_wdata.fail_cnt = '0;
              ent_vld_d[ep_q]    = 1'b1;
            end
            busy_d    = 1'b1;
            cur_ep_d  = ep_q;
            attempt_d = '0;
          end
        end else if (!busy_q) begin
          res_act_d = rbcb_pkg::ACT_ERROR;
        end else begin
          case (outcome_q)
            rbcb_pkg::OUT_OK: begin
              ram_we             = 1'b1;
              ram_wdata.fail_cnt = '0;
              ent_vld_d[ep_q]    = 1'b1;
              busy_d             = 1'b0;
              res_act_d          = rbcb_pkg::ACT_FINISH;
              res_sts_d          = rbcb_pkg::STS_OK;
            end
            rbcb_pkg::OUT_RETRYABLE: begin
              if (attempt_q < retry_limit_q) begin
                // Start the serial multiply of the capped backoff by the jitter.
                b_d       = b_cap;
                attempt_d = attempt_q + 1'b1;
                res_act_d = rbcb_pkg::ACT_WAIT;
                mcand_d   = {1'b0, b_cap};
                mplier_d  = {jitter_frac_q, {(rbcb_pkg::DRAW_W - rbcb_pkg::JITTER_W){1'b0}}};
                acc_d     = '0;
                step_d    = '0;
                state_d   = ST_MUL1;
              end else begin
                // Retries used up: record the failure.
                ram_we              = 1'b1;
                ram_wdata.fail_cnt  = cnt_inc;
                ram_wdata.fail_time = now_q;
                ent_vld_d[ep_q]     = 1'b1;
                if (cnt_inc >= fail_thresh_q) begin
                  res_open_d = !bo_q[ep_q];
                  bo_d[ep_q] = 1'b1;
                end
                busy_d    = 1'b0;
                res_act_d = rbcb_pkg::ACT_FINISH;
                res_sts_d = rbcb_pkg::STS_RETRYABLE;
              end
            end
            default: begin
              busy_d    = 1'b0;
              res_act_d = rbcb_pkg::ACT_FINISH;
              res_sts_d = rbcb_pkg::STS_NONRETRYABLE;
            end
          endcase
        end
      end

      ST_MUL1, ST_MUL2: begin
        // One multiplier bit per cycle, most significant first.
        acc_d    = {acc_q[rbcb_pkg::ACC_W-2:0], 1'b0}
                   + (mplier_q[rbcb_pkg::DRAW_W-1]
                      ? {{rbcb_pkg::DRAW_W{1'b0}}, mcand_q} : '0);
        mplier_d = {mplier_q[rbcb_pkg::DRAW_W-2:0], 1'b0};
        step_d   = step_q + 1'b1;
        if (state_q == ST_MUL1 && step_q == MUL1_LAST) begin
          state_d = ST_MID;
        end else if (state_q == ST_MUL2 && step_q == MUL2_LAST) begin
          state_d = ST_SUM;
        end
      end

      ST_MID: begin
        // Jitter span known: either no jitter, or scale the draw by 2j + 1.
        if (j_new == '0) begin
          res_delay_d = {1'b0, b_q};
          state_d     = ST_DONE;
        end else begin
          j_d      = j_new;
          mcand_d  = {j_new, 1'b1};
          mplier_d = draw_q;
          acc_d    = '0;
          step_d   = '0;
          state_d  = ST_MUL2;
        end
      end

      ST_SUM: begin
        res_delay_d = {1'b0, b_q} - {1'b0, j_q}
                      + acc_q[rbcb_pkg::ACC_W-1:rbcb_pkg::DRAW_W];
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      cur_ep_q  <= '0;
      attempt_q <= '0;
      bo_q      <= '0;
      ent_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      cur_ep_q  <= cur_ep_d;
      attempt_q <= attempt_d;
      bo_q      <= bo_d;
      ent_vld_q <= ent_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request capture and datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= in_i.mode;
      outcome_q <= in_i.outcome;
      draw_q    <= in_i.random_draw;
      now_q     <= in_i.now_ms;
      ep_q      <= rd_addr;
    end
    b_q         <= b_d;
    j_q         <= j_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    step_q      <= step_d;
    res_act_q   <= res_act_d;
    res_sts_q   <= res_sts_d;
    res_delay_q <= res_delay_d;
    res_open_q  <= res_open_d;
    if (out_load) begin
      out_act_q   <= res_act_q;
      out_sts_q   <= res_sts_q;
      out_delay_q <= res_delay_q;
      out_open_q  <= res_open_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.action         = out_act_q;
  assign out_o.final_status   = out_sts_q;
  assign out_o.delay_ms       = out_delay_q;
  assign out_o.breaker_opened = out_open_q;

  // An accepted request is decided in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_DECIDE)
    else $error("accepted request not decided next cycle");

  // Opening a breaker only happens on a finished, retryable request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_open_q) |->
      (out_act_q == rbcb_pkg::ACT_FINISH && out_sts_q == rbcb_pkg::STS_RETRYABLE))
    else $error("breaker opened on a result that is not a retryable finish");

  // Status and delay stay zero unless the action uses them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_act_q != rbcb_pkg::ACT_FINISH) |->
      (out_sts_q == rbcb_pkg::STS_OK && !out_open_q))
    else $error("status set on a result that is not a finish");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_act_q != rbcb_pkg::ACT_WAIT) |-> out_delay_q == '0)
    else $error("delay set on a result that is not a wait");

endmodule

// ===== hw/rtl/rbcb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rbcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/retry_backoff_circuit_breaker_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the retry controller with per-endpoint breakers.
// Depends on rbcb_pkg, rbcb_in_if, rbcb_out_if and the core RTL; needs no files.
module retry_backoff_circuit_breaker_core_test;
  import rbcb_pkg::*;

  localparam int unsigned EP_COUNT = ENDPOINT_COUNT_DEF;
  localparam logic [OUTCOME_W-1:0] OUT_NONRETRYABLE = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_RESERVED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ENDPOINT_W-1:0] endpoint;
    logic [OUTCOME_W-1:0]  outcome;
    logic [DRAW_W-1:0]     draw;
    logic [TIME_W-1:0]     now_ms;
  } request_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [STATUS_W-1:0] status;
    logic [DELAY_W-1:0]  delay;
    logic                opened;
  } result_t;

  // Tracks breaker state and registers, and queues the result of each request.
  class breaker_predictor;
    logic [RETRIES_W-1:0]   retry_limit;
    logic [BASE_W-1:0]      base_delay;
    logic [BACKOFF_W-1:0]   max_backoff;
    logic [JITTER_W-1:0]    jitter;
    logic [THRESHOLD_W-1:0] threshold;
    logic [TIME_W-1:0]      reset_ms;
    logic                   bkr_open [EP_COUNT];
    logic [FAILCNT_W-1:0]   fail_cnt [EP_COUNT];
    logic [TIME_W-1:0]      fail_time [EP_COUNT];
    logic                   busy;
    logic [ENDPOINT_W-1:0]  cur_ep;
    logic [RETRIES_W-1:0]   attempt;
    result_t                expected_results [$];
    int unsigned            mismatches;

    function new();
      retry_limit = RETRY_LIMIT_RST;
      base_delay  = BASE_DELAY_RST;
      max_backoff = MAX_BACKOFF_RST;
      jitter      = JITTER_FRAC_RST;
      threshold   = FAIL_THRESHOLD_RST;
      reset_ms    = BREAKER_RESET_RST;
      for (int i = 0; i < EP_COUNT; i++) begin
        bkr_open[i]  = 1'b0;
        fail_cnt[i]  = '0;
        fail_time[i] = '0;
      end
      busy = 1'b0;
      cur_ep = '0;
      attempt = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RETRY_LIMIT:    retry_limit = data[RETRIES_W-1:0];
        REG_BASE_DELAY:     base_delay  = data[BASE_W-1:0];
        REG_MAX_BACKOFF:    max_backoff = data[BACKOFF_W-1:0];
        REG_JITTER_FRAC:    jitter      = data[JITTER_W-1:0];
        REG_FAIL_THRESHOLD: threshold   = data[THRESHOLD_W-1:0];
        REG_BREAKER_RESET:  reset_ms    = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    // Capped exponential backoff with symmetric jitter around the capped value.
    function logic [DELAY_W-1:0] backoff(logic [RETRIES_W-1:0] step, logic [DRAW_W-1:0] draw);
      logic [63:0] b;
      logic [63:0] j;
      b = 64'(base_delay) << step;
      if (b > 64'(max_backoff)) b = 64'(max_backoff);
      j = (b * 64'(jitter)) >> 8;
      if (j != 0) b = b - j + ((64'(draw) * (2 * j + 1)) >> 16);
      return b[DELAY_W-1:0];
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(request_t r);
      result_t e;
      logic [ENDPOINT_W-1:0] ep;
      logic [TIME_W-1:0] age;
      logic allow;
      e = '0;
      e.action = ACT_SUBMIT;
      e.status = STS_OK;
      if (r.mode == MODE_START) begin
        if (busy) begin
          e.action = ACT_ERROR;
        end else begin
          ep = ENDPOINT_W'(r.endpoint % EP_COUNT);
          allow = 1'b1;
          if (bkr_open[ep]) begin
            age = r.now_ms - fail_time[ep];
            if (age > reset_ms) begin
              bkr_open[ep] = 1'b0;
              fail_cnt[ep] = '0;
            end else begin
              allow = 1'b0;
            end
          end
          if (allow) begin
            busy = 1'b1;
            cur_ep = ep;
            attempt = '0;
          end else begin
            e.action = ACT_FINISH;
            e.status = STS_BREAKER_OPEN;
          end
        end
      end else if (!busy) begin
        e.action = ACT_ERROR;
      end else if (r.outcome == OUT_OK) begin
        fail_cnt[cur_ep] = '0;
        busy = 1'b0;
        e.action = ACT_FINISH;
      end else if (r.outcome == OUT_RETRYABLE) begin
        if (attempt < retry_limit) begin
          e.delay = backoff(attempt, r.draw);
          attempt = attempt + 1'b1;
          e.action = ACT_WAIT;
        end else begin
          // Retries used up: count the failure and maybe trip the breaker.
          if (fail_cnt[cur_ep] != 8'hFF) fail_cnt[cur_ep] = fail_cnt[cur_ep] + 1'b1;
          fail_time[cur_ep] = r.now_ms;
          if (fail_cnt[cur_ep] >= threshold) begin
            if (!bkr_open[cur_ep]) e.opened = 1'b1;
            bkr_open[cur_ep] = 1'b1;
          end
          busy = 1'b0;
          e.action = ACT_FINISH;
          e.status = STS_RETRYABLE;
        end
      end else begin
        // Non-retryable and the unused code both end the request.
        busy = 1'b0;
        e.action = ACT_FINISH;
        e.status = STS_NONRETRYABLE;
      end
      expected_results.push_back(e);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Compares one delivered result against the oldest queued one.
    function void check_result(result_t got);
      result_t e;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result: action %0d status %0d delay %0d opened %0d",
                       got.action, got.status, got.delay, got.opened));
      end else begin
        e = expected_results.pop_front();
        if (got.action !== e.action || got.status !== e.status ||
            got.delay !== e.delay || got.opened !== e.opened) begin
          flag($sformatf({"result mismatch: expected action %0d status %0d delay %0d ",
                          "opened %0d, got action %0d status %0d delay %0d opened %0d"},
                         e.action, e.status, e.delay, e.opened,
                         got.action, got.status, got.delay, got.opened));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rbcb_in_if  req_if ();
  rbcb_out_if res_if ();

  retry_backoff_circuit_breaker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  breaker_predictor sb = new();
  logic quiet = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check every delivered result and stall at random. Twice it
  // holds off for a long stretch so that the block backs up its request side.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned results_seen;
    result_t got;
    stall_left = 0;
    hold_left = 0;
    results_seen = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got.action = res_if.action;
        got.status = res_if.final_status;
        got.delay  = res_if.delay_ms;
        got.opened = res_if.breaker_opened;
        sb.check_result(got);
        results_seen++;
        if (results_seen == 150 || results_seen == 1200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic request_t mk_request(logic [MODE_W-1:0] mode, logic [ENDPOINT_W-1:0] ep,
                                          logic [OUTCOME_W-1:0] outcome,
                                          logic [DRAW_W-1:0] draw, logic [TIME_W-1:0] now_ms);
    request_t r;
    r.mode = mode;
    r.endpoint = ep;
    r.outcome = outcome;
    r.draw = draw;
    r.now_ms = now_ms;
    return r;
  endfunction

  // Builds the next random request: mostly well-formed start/outcome sequences,
  // with a few out-of-order requests mixed in.
  function automatic request_t next_request();
    request_t r;
    int unsigned pick;
    r.endpoint = ($urandom_range(0, 2) != 0) ? ENDPOINT_W'($urandom_range(0, 3))
                                              : ENDPOINT_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 15) r.outcome = OUT_OK;
    else if (pick < 80) r.outcome = OUT_RETRYABLE;
    else if (pick < 92) r.outcome = OUT_NONRETRYABLE;
    else r.outcome = OUT_RESERVED;
    case ($urandom_range(0, 7))
      0: r.draw = '0;
      1: r.draw = '1;
      default: r.draw = DRAW_W'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 99) < 7) r.mode = sb.busy ? MODE_START : MODE_OUTCOME;
    else r.mode = sb.busy ? MODE_OUTCOME : MODE_START;
    // Time mostly moves forward; sometimes it lands right on the reset boundary.
    case ($urandom_range(0, 9))
      0: r.now_ms = $urandom;
      1: r.now_ms = sb.fail_time[r.endpoint] + sb.reset_ms + $urandom_range(0, 1);
      default: begin
        clock_ms = clock_ms + $urandom_range(0, (sb.reset_ms >> 2) + 4);
        r.now_ms = clock_ms;
      end
    endcase
    return r;
  endfunction

  // Offers one request and waits for it to be taken, then maybe idles.
  task automatic send_request(request_t r);
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.endpoint    <= r.endpoint;
    req_if.outcome     <= r.outcome;
    req_if.random_draw <= r.draw;
    req_if.now_ms      <= r.now_ms;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering requests and waits until every queued result has come back.
  task automatic drain();
    int unsigned n;
    n = 0;
    req_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned count, logic [31:0] retries, logic [31:0] base,
                           logic [31:0] cap, logic [31:0] jit, logic [31:0] thresh,
                           logic [31:0] reset_time);
    drain();
    write_reg(REG_RETRY_LIMIT, retries);
    write_reg(REG_BASE_DELAY, base);
    write_reg(REG_MAX_BACKOFF, cap);
    write_reg(REG_JITTER_FRAC, jit);
    write_reg(REG_FAIL_THRESHOLD, thresh);
    write_reg(REG_BREAKER_RESET, reset_time);
    repeat (count) send_request(next_request());
  endtask

  // Main sequence: reset, directed requests, then randomized phases.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_START;
    req_if.endpoint = '0;
    req_if.outcome = OUT_OK;
    req_if.random_draw = '0;
    req_if.now_ms = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: out-of-order requests, full retry chain, all outcomes.
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_OK, 16'h0000, 32'd0));
    send_request(mk_request(MODE_START, 4'd15, OUT_OK, 16'h0000, 32'd0));
    send_request(mk_request(MODE_START, 4'd3, OUT_OK, 16'h0000, 32'd5));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RETRYABLE, 16'h0000, 32'd10));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RETRYABLE, 16'hFFFF, 32'd20));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RETRYABLE, 16'h8000, 32'd30));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RETRYABLE, 16'h1234, 32'd40));
    send_request(mk_request(MODE_START, 4'd15, OUT_OK, 16'h0000, 32'd50));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RESERVED, 16'h0000, 32'd60));
    send_request(mk_request(MODE_START, 4'd0, OUT_OK, 16'h0000, 32'd70));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_NONRETRYABLE, 16'h0000, 32'd80));
    send_request(mk_request(MODE_START, 4'd10, OUT_OK, 16'h0000, 32'd90));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_OK, 16'h0000, 32'd100));

    // Zero threshold trips on the first failure; reopen check across time wrap,
    // first at exactly the reset time and then one past it.
    drain();
    write_reg(REG_FAIL_THRESHOLD, 32'd0);
    write_reg(REG_RETRY_LIMIT, 32'd0);
    write_reg(REG_BREAKER_RESET, 32'd100);
    send_request(mk_request(MODE_START, 4'd0, OUT_OK, 16'h0000, 32'hFFFF_FFF0));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_RETRYABLE, 16'h0000, 32'hFFFF_FFF0));
    send_request(mk_request(MODE_START, 4'd0, OUT_OK, 16'h0000, 32'h0000_0054));
    send_request(mk_request(MODE_START, 4'd0, OUT_OK, 16'h0000, 32'h0000_0055));
    send_request(mk_request(MODE_OUTCOME, 4'd0, OUT_OK, 16'h0000, 32'h0000_0060));
    clock_ms = 32'h0000_0100;

    // Randomized phases, the register extremes among them.
    run_phase(260, 32'd3, 32'd100, 32'd5000, 32'd64, 32'd5, 32'd30000);
    run_phase(200, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_phase(260, 32'd15, 32'd65535, 32'hFF_FFFF, 32'd255, 32'd255, 32'hFFFF_FFFF);
    run_phase(200, 32'd15, 32'd65535, 32'hFF_FFFF, 32'd255, 32'd1, 32'd0);
    run_phase(240, 32'd7, 32'd1, 32'hFF_FFFF, 32'd128, 32'd2, 32'd500);
    repeat (2) begin
      run_phase(240, $urandom_range(0, 15), $urandom_range(0, 65535),
                $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 255),
                $urandom_range(0, 8), $urandom_range(0, 5000));
    end
    // Final stretch runs at full rate on both sides.
    quiet = 1'b1;
    run_phase(300, 32'd4, 32'd300, 32'd20000, 32'd200, 32'd3, 32'd2000);

    drain();
    if (sb.expected_results.size() != 0) begin
      sb.flag($sformatf("%0d results never arrived", sb.expected_results.size()));
    end
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
